// File: rtl/rgb_to_hsl_convert_top_assert.svh
// ----------------------------------------------------------------------------
// rgb to hsl converter assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERT_TOP_ASSERT_SVH
`define RGB_TO_HSL_CONVERT_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define RHC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define RHC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rgb to hsl converter package
// payload types, pipeline stage types and divider step counts
// ----------------------------------------------------------------------------
package rhc_pkg;

	// divider steps done in each divide stage
	localparam int SAT_STEPS = 4;
	localparam int HUE_STEPS = 3;
	localparam int DIV_STAGES = 4;
	localparam int SAT_QW = SAT_STEPS * DIV_STAGES;
	localparam int HUE_QW = HUE_STEPS * DIV_STAGES;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [8:0]  hue_degrees;
		logic [15:0] saturation;
		logic [8:0]  lightness_sum;
		logic [7:0]  alpha_out;
	} hsl_t;

	// after max/min and hue numerator
	typedef struct packed {
		logic [7:0]  delta;
		logic [7:0]  sat_den;
		logic [7:0]  hue_dvs;
		logic [10:0] hue_num;
		logic [8:0]  sum;
		logic [7:0]  alpha;
	} prep_t;

	// two restoring dividers in flight
	typedef struct packed {
		logic [7:0]        sat_rem;
		logic [7:0]        sat_den;
		logic [SAT_QW-1:0] sat_dvd;
		logic [SAT_QW-1:0] sat_q;
		logic [7:0]        hue_rem;
		logic [7:0]        hue_dvs;
		logic [HUE_QW-1:0] hue_dvd;
		logic [HUE_QW-1:0] hue_q;
		logic [8:0]        sum;
		logic [7:0]        alpha;
	} div_t;

endpackage

// File: rtl/rhc_prep.sv
// ----------------------------------------------------------------------------
// rgb to hsl prep
// max, min, delta, lightness sum, saturation divisor and hue numerator
// ----------------------------------------------------------------------------
module rhc_prep (
	input  rhc_pkg::pixel_t pixel,
	output rhc_pkg::prep_t  prep
);
	import rhc_pkg::*;

	logic              r_max;
	logic              g_max;
	logic [7:0]        mx;
	logic [7:0]        mn;
	logic [7:0]        delta;
	logic [8:0]        sum;
	logic [8:0]        den_hi;
	logic signed [11:0] d_s;
	logic signed [11:0] n_raw;
	logic signed [11:0] n_adj;

	always_comb begin
		r_max = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
		g_max = !r_max && (pixel.green >= pixel.blue);
		if (r_max) begin
			mx = pixel.red;
		end else if (g_max) begin
			mx = pixel.green;
		end else begin
			mx = pixel.blue;
		end
		if ((pixel.red <= pixel.green) && (pixel.red <= pixel.blue)) begin
			mn = pixel.red;
		end else if (pixel.green <= pixel.blue) begin
			mn = pixel.green;
		end else begin
			mn = pixel.blue;
		end
		delta = mx - mn;
		sum = {1'b0, mx} + {1'b0, mn};
		den_hi = 9'd510 - sum;
		d_s = $signed({4'b0, delta});

		priority if (r_max) begin
			n_raw = $signed({4'b0, pixel.green}) - $signed({4'b0, pixel.blue});
		end else if (g_max) begin
			n_raw = (d_s <<< 1) + $signed({4'b0, pixel.blue}) - $signed({4'b0, pixel.red});
		end else begin
			n_raw = (d_s <<< 2) + $signed({4'b0, pixel.red}) - $signed({4'b0, pixel.green});
		end
		n_adj = (n_raw < 0) ? (n_raw + (d_s <<< 2) + (d_s <<< 1)) : n_raw;

		prep.delta = delta;
		prep.sum = sum;
		prep.alpha = pixel.alpha;
		prep.hue_num = n_adj[10:0];
		// gray pixel: unit divisors so both quotients come out zero
		if (delta == 8'd0) begin
			prep.sat_den = 8'd1;
			prep.hue_dvs = 8'd1;
		end else begin
			prep.sat_den = (sum <= 9'd255) ? sum[7:0] : den_hi[7:0];
			prep.hue_dvs = delta;
		end
	end

endmodule

// File: rtl/rhc_setup.sv
// ----------------------------------------------------------------------------
// rgb to hsl divider setup
// scales the hue numerator by 60 and loads both dividers
// ----------------------------------------------------------------------------
module rhc_setup (
	input  rhc_pkg::prep_t prep,
	output rhc_pkg::div_t  div
);
	import rhc_pkg::*;

	logic [16:0] hue_x;

	always_comb begin
		// n * 60 as n * 64 - n * 4
		hue_x = ({prep.hue_num, 6'b0}) - ({4'b0, prep.hue_num, 2'b0});

		// delta << 15 over the divisor; top part delta >> 1 starts the remainder
		div.sat_rem = {1'b0, prep.delta[7:1]};
		div.sat_den = prep.sat_den;
		div.sat_dvd = {prep.delta[0], {(SAT_QW - 1){1'b0}}};
		div.sat_q = '0;

		// hue quotient is below 360, so the bits above the quotient width start it
		div.hue_rem = {3'b0, hue_x[16:HUE_QW]};
		div.hue_dvs = prep.hue_dvs;
		div.hue_dvd = hue_x[HUE_QW-1:0];
		div.hue_q = '0;

		div.sum = prep.sum;
		div.alpha = prep.alpha;
	end

endmodule

// File: rtl/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rgb to hsl divide step
// four restoring steps of the saturation divider and three of the hue divider
// ----------------------------------------------------------------------------
module rhc_div_step (
	input  rhc_pkg::div_t d_in,
	output rhc_pkg::div_t d_out
);
	import rhc_pkg::*;

	logic [8:0] rem9;

	always_comb begin
		rem9 = '0;
		d_out = d_in;
		for (int k = 0; k < SAT_STEPS; k++) begin
			rem9 = {d_out.sat_rem, d_out.sat_dvd[SAT_QW-1]};
			d_out.sat_dvd = {d_out.sat_dvd[SAT_QW-2:0], 1'b0};
			if (rem9 >= {1'b0, d_out.sat_den}) begin
				rem9 = rem9 - {1'b0, d_out.sat_den};
				d_out.sat_q = {d_out.sat_q[SAT_QW-2:0], 1'b1};
			end else begin
				d_out.sat_q = {d_out.sat_q[SAT_QW-2:0], 1'b0};
			end
			d_out.sat_rem = rem9[7:0];
		end
		for (int k = 0; k < HUE_STEPS; k++) begin
			rem9 = {d_out.hue_rem, d_out.hue_dvd[HUE_QW-1]};
			d_out.hue_dvd = {d_out.hue_dvd[HUE_QW-2:0], 1'b0};
			if (rem9 >= {1'b0, d_out.hue_dvs}) begin
				rem9 = rem9 - {1'b0, d_out.hue_dvs};
				d_out.hue_q = {d_out.hue_q[HUE_QW-2:0], 1'b1};
			end else begin
				d_out.hue_q = {d_out.hue_q[HUE_QW-2:0], 1'b0};
			end
			d_out.hue_rem = rem9[7:0];
		end
	end

endmodule

// File: rtl/rgb_to_hsl_convert_top.sv
// ----------------------------------------------------------------------------
// rgb to hsl converter
// pipelined rgba to hsl conversion with exact integer hue and saturation
// ----------------------------------------------------------------------------
//  port    dir  payload  handshake
//  pixel   in   pixel_t  pixel_valid / pixel_stall
//  hsl     out  hsl_t    hsl_valid / hsl_stall
//
//  one pixel per clock sustained while hsl_stall is low, each pixel registered in stages 1 to 6 in turn
//  stage 1 max/min and hue numerator, stage 2 scale and divider load,
//  stages 3 to 6 four saturation and three hue restoring steps each
//  a stall only holds stages that are full, empty stages keep filling
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  rhc_pkg::pixel_t pixel,
	output logic            hsl_valid,
	input  logic            hsl_stall,
	output rhc_pkg::hsl_t   hsl
);
	import rhc_pkg::*;

	prep_t prep_c;
	div_t  setup_c;
	div_t  div3_c;
	div_t  div4_c;
	div_t  div5_c;
	div_t  div6_c;

	prep_t prep_s1;
	div_t  div_s2;
	div_t  div_s3;
	div_t  div_s4;
	div_t  div_s5;
	div_t  div_s6;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic valid_s6;

	logic en1;
	logic en2;
	logic en3;
	logic en4;
	logic en5;
	logic en6;

	rhc_prep     u_prep  (.pixel(pixel),   .prep(prep_c));
	rhc_setup    u_setup (.prep(prep_s1),  .div(setup_c));
	rhc_div_step u_div3  (.d_in(div_s2),   .d_out(div3_c));
	rhc_div_step u_div4  (.d_in(div_s3),   .d_out(div4_c));
	rhc_div_step u_div5  (.d_in(div_s4),   .d_out(div5_c));
	rhc_div_step u_div6  (.d_in(div_s5),   .d_out(div6_c));

	// a stage loads when empty or when the next one moves
	assign en6 = !valid_s6 || !hsl_stall;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pixel_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= pixel_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pixel_valid) prep_s1 <= prep_c;
		if (en2 && valid_s1) div_s2 <= setup_c;
		if (en3 && valid_s2) div_s3 <= div3_c;
		if (en4 && valid_s3) div_s4 <= div4_c;
		if (en5 && valid_s4) div_s5 <= div5_c;
		if (en6 && valid_s5) div_s6 <= div6_c;
	end

	assign hsl_valid = valid_s6;
	assign hsl.hue_degrees = div_s6.hue_q[8:0];
	assign hsl.saturation = div_s6.sat_q[15:0];
	assign hsl.lightness_sum = div_s6.sum;
	assign hsl.alpha_out = div_s6.alpha;

endmodule

// File: rtl/rhc_check.sv
// ----------------------------------------------------------------------------
// rgb to hsl converter port checker
// watches the top level ports and is bound to the top level
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_convert_top_assert.svh"

module rhc_check (
	input logic            clk,
	input logic            arst_n,
	input logic            pixel_valid,
	input logic            pixel_stall,
	input rhc_pkg::pixel_t pixel,
	input logic            hsl_valid,
	input logic            hsl_stall,
	input rhc_pkg::hsl_t   hsl
);
	import rhc_pkg::*;

	// a stalled result stays offered
	`RHC_ASSERT_NXT(a_out_hold, clk, arst_n, hsl_valid && hsl_stall, hsl_valid, "result dropped while stalled")

	// hue never reaches a full turn
	`RHC_ASSERT_IMP(a_hue_range, clk, arst_n, hsl_valid, hsl.hue_degrees <= 9'd359, "hue out of range")

	// saturation never above one
	`RHC_ASSERT_IMP(a_sat_range, clk, arst_n, hsl_valid, hsl.saturation <= 16'd32768, "saturation above one")

	// gray result when max plus min is zero: black pixel
	`RHC_ASSERT_IMP(a_black, clk, arst_n, hsl_valid && (hsl.lightness_sum == 9'd0), (hsl.saturation == 16'd0) && (hsl.hue_degrees == 9'd0), "black pixel not gray")

	// an empty output stage never holds off a transfer
	`RHC_ASSERT_IMP(a_no_idle_stall, clk, arst_n, !hsl_valid, !pixel_stall, "stall with empty output")

endmodule

bind rgb_to_hsl_convert_top rhc_check u_rhc_check (
	.clk(clk),
	.arst_n(arst_n),
	.pixel_valid(pixel_valid),
	.pixel_stall(pixel_stall),
	.pixel(pixel),
	.hsl_valid(hsl_valid),
	.hsl_stall(hsl_stall),
	.hsl(hsl)
);
